// File: rtl/core/sssg_pkg.sv
`timescale 1ns / 1ps
// sssg_pkg: shared types, constants and the sine table function of the
// scrolling sine segment generator; no dependencies
package sssg_pkg;

    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int MAX_POINTS           = 256;
    localparam int IDX_W                = 8;
    localparam int IDX_CMP_W            = 13;
    localparam int K_W                  = IDX_W + 1;
    localparam int OFF_W                = 20;
    localparam int T_W                  = OFF_W + 1;
    localparam int DIV_W                = 20;
    localparam int CFG_IDX_W            = 3;
    localparam int CFG_DATA_W           = 20;
    localparam int MF_W                 = 17;
    localparam int QUEUE_DEPTH          = 2;
    localparam int QPTR_W               = 1;

    localparam logic [MF_W-1:0] MF_ONE = MF_W'(65536);

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] C1      = 64'd1686629713;
    localparam logic [63:0] C3      = 64'd693598670;
    localparam logic [63:0] C5      = 64'd85569306;
    localparam logic [63:0] C7      = 64'd5026995;
    localparam logic [63:0] C9      = 64'd172271;
    localparam logic [63:0] C11     = 64'd3864;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_Y     = 3'd0,
        CFG_AMPLITUDE  = 3'd1,
        CFG_PERIOD     = 3'd2,
        CFG_PHASE_STEP = 3'd3,
        CFG_MOD_PERIOD = 3'd4,
        CFG_MOD_ENABLE = 3'd5,
        CFG_X_STEP     = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_ROM,
        ST_MUL,
        ST_MUL2,
        ST_SUM,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        P_MOD,
        P_Y0,
        P_Y1
    } t_pass;

    typedef struct packed {
        logic signed [12:0] base_y;
        logic [9:0]         amplitude;
        logic [11:0]        period_points;
        logic [19:0]        phase_step;
        logic [11:0]        mod_period;
        logic               mod_enable;
        logic [19:0]        x_step;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [OFF_W-1:0] offset;
    } t_item;

    // magnitude of sine table entry k for a table of 2^lg entries
    function automatic logic [14:0] sine_mag(input int unsigned k, input int unsigned lg);
        logic [63:0] p;
        logic [63:0] u;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] r;
        logic [63:0] v;
        logic [63:0] s;
        p  = 64'(k) << (32 - lg);
        u  = {34'd0, p[29:0]};
        z  = p[30] ? (Q30_ONE - u) : u;
        z2 = (z * z) >> 30;
        r  = C11;
        r  = C9 - ((z2 * r) >> 30);
        r  = C7 - ((z2 * r) >> 30);
        r  = C5 - ((z2 * r) >> 30);
        r  = C3 - ((z2 * r) >> 30);
        r  = C1 - ((z2 * r) >> 30);
        v  = (z * r) >> 30;
        s  = (v + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[14:0];
    endfunction

endpackage

// File: rtl/core/sssg_sine_rom.sv
`timescale 1ns / 1ps
// sssg_sine_rom: q1.15 sine table, quarter wave folded, registered read
// depends on sssg_pkg
module sssg_sine_rom #(
    parameter int DEPTH = sssg_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    output logic signed [15:0]         o_data
);
    import sssg_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int QD = DEPTH / 4;
    localparam int QW = AW - 1;

    logic [14:0]       w_quarter [QD+1];
    logic [QW-1:0]     w_idx;
    logic [14:0]       w_mag;
    logic signed [15:0] r_data;

    for (genvar g = 0; g <= QD; g++) begin : g_tab
        assign w_quarter[g] = sine_mag(g, AW);
    end

    assign w_idx = i_addr[AW-2] ? (QW'(QD) - {1'b0, i_addr[AW-3:0]})
                                : {1'b0, i_addr[AW-3:0]};
    assign w_mag = w_quarter[w_idx];

    always_ff @(posedge i_clk) begin
        r_data <= i_addr[AW-1] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
    end

    assign o_data = r_data;

endmodule

// File: rtl/core/sssg_div.sv
`timescale 1ns / 1ps
// sssg_div: restoring divider, one quotient bit per cycle, low quotient bits out
// depends on sssg_pkg
module sssg_div #(
    parameter int DW = 31,
    parameter int QW = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DW-1:0]             i_dividend,
    input  logic [sssg_pkg::DIV_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [QW-1:0]             o_quotient
);
    import sssg_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]    r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dvs;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W:0]   w_trial;
    logic             w_fit;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_fit   = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? DIV_W'(w_trial - {1'b0, r_dvs}) : DIV_W'(w_trial);
            r_quo <= {r_quo[DW-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[QW-1:0];

endmodule

// File: rtl/core/sssg_queue.sv
`timescale 1ns / 1ps
// sssg_queue: short transaction queue between front and back
// depends on sssg_pkg
module sssg_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sssg_pkg::t_item      i_item,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output sssg_pkg::t_item      o_item
);
    import sssg_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_full  = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
`endif

endmodule

// File: rtl/core/sssg_front.sv
`timescale 1ns / 1ps
// sssg_front: configuration registers, phase offset advance and index clamp
// depends on sssg_pkg
module sssg_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [sssg_pkg::IDX_W-1:0]       i_point_index,
    input  logic                             i_advance,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sssg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sssg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output sssg_pkg::t_cfg                   o_cfg,
    output logic                             o_push,
    output sssg_pkg::t_item                  o_push_item,
    input  logic                             i_full
);
    import sssg_pkg::*;

    t_cfg             r_cfg;
    logic [OFF_W-1:0] r_offset;
    logic [11:0]      w_pe;
    logic [OFF_W-1:0] w_span;
    logic [OFF_W-1:0] w_step;
    logic [OFF_W:0]   w_sum;
    logic [OFF_W:0]   w_wrap;
    logic [OFF_W-1:0] w_next_off;
    logic [IDX_W-1:0] w_idx;
    logic             w_accept;

    assign o_stall     = i_full;
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
    assign w_accept    = i_valid && !o_stall;

    assign w_pe       = (r_cfg.period_points == '0) ? 12'd1 : r_cfg.period_points;
    assign w_span     = {w_pe, 8'd0};
    assign w_step     = (r_cfg.phase_step > w_span) ? w_span : r_cfg.phase_step;
    assign w_sum      = {1'b0, r_offset} + {1'b0, w_step};
    assign w_wrap     = (w_sum >= {1'b0, w_span}) ? (w_sum - {1'b0, w_span}) : w_sum;
    assign w_next_off = w_wrap[OFF_W-1:0];

    assign w_idx = (IDX_CMP_W'(i_point_index) >= IDX_CMP_W'(MAX_POINTS))
                 ? IDX_W'(MAX_POINTS - 1) : i_point_index;

    assign o_push             = w_accept;
    assign o_push_item.idx    = w_idx;
    assign o_push_item.offset = i_advance ? w_next_off : r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (w_accept && i_advance) begin
            r_offset <= w_next_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_y        <= 13'sd0;
            r_cfg.amplitude     <= 10'd50;
            r_cfg.period_points <= 12'd100;
            r_cfg.phase_step    <= 20'd512;
            r_cfg.mod_period    <= 12'd50;
            r_cfg.mod_enable    <= 1'b0;
            r_cfg.x_step        <= 20'd1638;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BASE_Y:     r_cfg.base_y        <= $signed(i_cfg_data[12:0]);
                CFG_AMPLITUDE:  r_cfg.amplitude     <= i_cfg_data[9:0];
                CFG_PERIOD:     r_cfg.period_points <= i_cfg_data[11:0];
                CFG_PHASE_STEP: r_cfg.phase_step    <= i_cfg_data[19:0];
                CFG_MOD_PERIOD: r_cfg.mod_period    <= i_cfg_data[11:0];
                CFG_MOD_ENABLE: r_cfg.mod_enable    <= i_cfg_data[0];
                CFG_X_STEP:     r_cfg.x_step        <= i_cfg_data[19:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/core/sssg_back.sv
`timescale 1ns / 1ps
// sssg_back: sequencer computing one segment per transaction
// depends on sssg_pkg, sssg_sine_rom, sssg_div
module sssg_back #(
    parameter int SINE_DEPTH = sssg_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sssg_pkg::t_cfg       i_cfg,
    input  logic                 i_q_valid,
    input  sssg_pkg::t_item      i_q_item,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [15:0]          o_seg_x_start,
    output logic signed [13:0]   o_seg_y_start,
    output logic [15:0]          o_seg_x_end,
    output logic signed [13:0]   o_seg_y_end
);
    import sssg_pkg::*;

    localparam int AW = $clog2(SINE_DEPTH);
    localparam int DW = T_W + AW;

    t_state              r_state;
    t_state              n_state;
    t_pass               r_pass;
    logic [IDX_W-1:0]    r_idx;
    logic [OFF_W-1:0]    r_off;
    logic [AW-1:0]       r_addr;
    logic [MF_W-1:0]     r_mf;
    logic signed [26:0]  r_as;
    logic signed [44:0]  r_prod;
    logic [15:0]         r_x0;
    logic [15:0]         r_x1;
    logic signed [13:0]  r_y0;
    logic signed [13:0]  r_y1;
    logic                r_out_valid;
    logic [15:0]         r_ox0;
    logic [15:0]         r_ox1;
    logic signed [13:0]  r_oy0;
    logic signed [13:0]  r_oy1;

    logic                w_div_start;
    logic                w_div_done;
    logic [AW-1:0]       w_div_q;
    logic signed [15:0]  w_rom_data;
    logic [K_W-1:0]      w_k;
    logic [11:0]         w_pe;
    logic [11:0]         w_me;
    logic [T_W-1:0]      w_t;
    logic [DW-1:0]       w_dividend;
    logic [DIV_W-1:0]    w_divisor;
    logic [28:0]         w_xprod;
    logic [15:0]         w_xsat;
    logic signed [26:0]  w_as;
    logic signed [17:0]  w_mf_sum;
    logic signed [45:0]  w_total;
    logic                w_round;
    logic signed [15:0]  w_qc;
    logic signed [13:0]  w_ysat;
    logic                w_load;

    sssg_div #(.DW(DW), .QW(AW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    sssg_sine_rom #(.DEPTH(SINE_DEPTH)) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_addr),
        .o_data (w_rom_data)
    );

    assign w_k  = K_W'(r_idx) + K_W'(r_pass == P_Y1);
    assign w_pe = (i_cfg.period_points == '0) ? 12'd1 : i_cfg.period_points;
    assign w_me = (i_cfg.mod_period == '0) ? 12'd1 : i_cfg.mod_period;
    assign w_t  = T_W'({w_k, 8'd0}) + T_W'(r_off);

    assign w_dividend = (r_pass == P_MOD) ? DW'({r_idx, {AW{1'b0}}}) : {w_t, {AW{1'b0}}};
    assign w_divisor  = (r_pass == P_MOD) ? DIV_W'(w_me) : {w_pe, 8'd0};

    assign w_xprod = 29'(w_k) * 29'(i_cfg.x_step);
    assign w_xsat  = (|w_xprod[28:24]) ? 16'hFFFF : w_xprod[23:8];

    assign w_as     = $signed({1'b0, i_cfg.amplitude}) * w_rom_data;
    assign w_mf_sum = 18'sd65536 + 18'(w_rom_data);

    assign w_total = $signed({{2{i_cfg.base_y[12]}}, i_cfg.base_y, 31'd0}) + 46'(r_prod);
    assign w_round = w_total[45] && (|w_total[30:0]);
    assign w_qc    = $signed({w_total[45], w_total[45:31]} + {15'd0, w_round});
    assign w_ysat  = (w_qc > 16'sd8191)  ? 14'sd8191 :
                     (w_qc < -16'sd8192) ? -14'sd8192 : 14'(w_qc);

    assign w_load = (r_state == ST_OUT) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_ROM;
                end
            end
            ST_ROM:  n_state = ST_MUL;
            ST_MUL:  n_state = (r_pass == P_MOD) ? ST_START : ST_MUL2;
            ST_MUL2: n_state = ST_SUM;
            ST_SUM:  n_state = (r_pass == P_Y0) ? ST_START : ST_OUT;
            ST_OUT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pass      <= P_Y0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && i_q_valid) begin
                r_pass <= i_cfg.mod_enable ? P_MOD : P_Y0;
            end else if (r_state == ST_MUL && r_pass == P_MOD) begin
                r_pass <= P_Y0;
            end else if (r_state == ST_SUM && r_pass == P_Y0) begin
                r_pass <= P_Y1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_q_valid) begin
            r_idx <= i_q_item.idx;
            r_off <= i_q_item.offset;
            r_mf  <= MF_ONE;
        end
        if (r_state == ST_START && r_pass == P_Y0) begin
            r_x0 <= w_xsat;
        end
        if (r_state == ST_START && r_pass == P_Y1) begin
            r_x1 <= w_xsat;
        end
        if (r_state == ST_DIV && w_div_done) begin
            r_addr <= w_div_q;
        end
        if (r_state == ST_MUL) begin
            if (r_pass == P_MOD) begin
                r_mf <= w_mf_sum[MF_W-1:0];
            end else begin
                r_as <= w_as;
            end
        end
        if (r_state == ST_MUL2) begin
            r_prod <= r_as * $signed({1'b0, r_mf});
        end
        if (r_state == ST_SUM) begin
            if (r_pass == P_Y0) begin
                r_y0 <= w_ysat;
            end else begin
                r_y1 <= w_ysat;
            end
        end
        if (w_load) begin
            r_ox0 <= r_x0;
            r_ox1 <= r_x1;
            r_oy0 <= r_y0;
            r_oy1 <= r_y1;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_seg_x_start = r_ox0;
    assign o_seg_y_start = r_oy0;
    assign o_seg_x_end   = r_ox1;
    assign o_seg_y_end   = r_oy1;

`ifndef NO_ASSERTIONS
    a_out_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_pass == P_Y1))
        else $error("result stage reached before end point");
    a_sum_not_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM) |-> (r_pass != P_MOD))
        else $error("y sum on modulation pass");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_seg_x_start) &&
        $stable(o_seg_y_start) && $stable(o_seg_x_end) && $stable(o_seg_y_end)))
        else $error("stalled result changed");
`endif

endmodule

// File: rtl/core/scrolling_sine_segment_generator.sv
`timescale 1ns / 1ps
// scrolling_sine_segment_generator: top level, front, queue and back
// depends on sssg_pkg, sssg_front, sssg_queue, sssg_back
// Each transaction gives the segment from point i to point i+1 of a scrolling
// sine wave. The front applies the phase advance and index clamp at accept
// time and queues the transaction (two entries), so new items are taken while
// the back works. The back runs one shared bit-serial divider for each sine
// address, on a dividend of DW = 21 + log2(SINE_TABLE_DEPTH) bits (31 at the
// default depth): an item takes two divisions in plain mode and three in
// modulated mode; the back pops no new item before the last one is output.
// The sine table is a quarter-wave constant table with registered read; no init pass.
// Configuration port is always ready; indices beyond the register list are ignored.
module scrolling_sine_segment_generator #(
    parameter int SINE_TABLE_DEPTH = sssg_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [sssg_pkg::IDX_W-1:0]       i_point_index,
    input  logic                             i_advance,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [15:0]                      o_seg_x_start,
    output logic signed [13:0]               o_seg_y_start,
    output logic [15:0]                      o_seg_x_end,
    output logic signed [13:0]               o_seg_y_end,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sssg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sssg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sssg_pkg::*;

    t_cfg  w_cfg;
    logic  w_push;
    t_item w_push_item;
    logic  w_full;
    logic  w_pop;
    logic  w_q_valid;
    t_item w_q_item;

    sssg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_point_index (i_point_index),
        .i_advance     (i_advance),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_cfg         (w_cfg),
        .o_push        (w_push),
        .o_push_item   (w_push_item),
        .i_full        (w_full)
    );

    sssg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    sssg_back #(.SINE_DEPTH(SINE_TABLE_DEPTH)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_seg_x_start (o_seg_x_start),
        .o_seg_y_start (o_seg_y_start),
        .o_seg_x_end   (o_seg_x_end),
        .o_seg_y_end   (o_seg_y_end)
    );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for scrolling_sine_segment_generator, own segment predictor,
// random idling on both sides and register sweeps; depends on sssg_pkg and the rtl
module tb;
    import sssg_pkg::*;

    localparam int TABLE_N   = 1024;
    localparam int SETTLE    = 300;
    localparam int LIMIT     = 3000000;
    localparam longint unsigned Q30 = 64'd1073741824;

    typedef struct {
        logic [15:0]        x0;
        logic signed [13:0] y0;
        logic [15:0]        x1;
        logic signed [13:0] y1;
    } t_seg;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_stall;
    logic [IDX_W-1:0] i_point_index = '0;
    logic i_advance = 0;
    logic o_valid;
    logic i_stall = 0;
    logic [15:0] o_seg_x_start, o_seg_x_end;
    logic signed [13:0] o_seg_y_start, o_seg_y_end;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    scrolling_sine_segment_generator DUT (.*);

    int sine_tab [TABLE_N];
    logic signed [12:0] m_base_y;
    logic [9:0]  m_amp;
    logic [11:0] m_period, m_mod_period;
    logic [19:0] m_step, m_x_step, m_offset;
    logic        m_mod_en;

    t_seg segs_due [$];
    int errors = 0;
    int n_items = 0;
    int n_segs = 0;
    int tx_pct = 0;
    int rx_pct = 0;
    int hold_cnt = 0;
    int cycles = 0;

    function automatic int sine_entry(int k);
        longint unsigned p, u, z, z2, r, v, s;
        p = longint'(k) << 22;
        u = p & (Q30 - 1);
        z = p[30] ? (Q30 - u) : u;
        z2 = (z * z) >> 30;
        r = 64'd3864;
        r = 64'd172271 - ((z2 * r) >> 30);
        r = 64'd5026995 - ((z2 * r) >> 30);
        r = 64'd85569306 - ((z2 * r) >> 30);
        r = 64'd693598670 - ((z2 * r) >> 30);
        r = 64'd1686629713 - ((z2 * r) >> 30);
        v = (z * r) >> 30;
        s = (v + 64'd16384) >> 15;
        if (s > 32767) s = 32767;
        return p[31] ? -int'(s) : int'(s);
    endfunction

    function automatic logic [15:0] x_at(int k);
        longint unsigned x;
        x = (longint'(k) * m_x_step) >> 8;
        return (x > 65535) ? 16'hFFFF : x[15:0];
    endfunction

    function automatic logic signed [13:0] y_at(int k, longint mf);
        longint unsigned span, n, addr;
        longint total, y;
        span = longint'(m_period == 0 ? 1 : m_period) << 8;
        n = ((longint'(k) << 8) + m_offset) % span;
        addr = (n * TABLE_N) / span;
        total = longint'(m_base_y) * (64'sd1 << 31)
              + longint'(m_amp) * longint'(sine_tab[addr % TABLE_N]) * mf;
        y = total / (64'sd1 << 31);
        if (y > 8191) y = 8191;
        if (y < -8192) y = -8192;
        return y[13:0];
    endfunction

    function automatic t_seg next_segment(logic [7:0] idx, logic adv);
        t_seg e;
        longint mf;
        int unsigned span, stp, o, m, addr;
        mf = 65536;
        if (adv) begin
            span = (m_period == 0 ? 1 : m_period) << 8;
            stp = (m_step > span) ? span : m_step;
            o = m_offset + stp;
            if (o >= span) o -= span;
            m_offset = o[19:0];
        end
        if (m_mod_en) begin
            m = (m_mod_period == 0) ? 1 : m_mod_period;
            addr = ((idx % m) * TABLE_N) / m;
            mf = 65536 + sine_tab[addr % TABLE_N];
        end
        e.x0 = x_at(int'(idx));
        e.y0 = y_at(int'(idx), mf);
        e.x1 = x_at(int'(idx) + 1);
        e.y1 = y_at(int'(idx) + 1, mf);
        return e;
    endfunction

    initial forever #5 i_clk = ~i_clk;

    initial forever begin
        @(posedge i_clk);
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d segments pending", cycles, segs_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // accepted input transaction -> predicted segment
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            segs_due.push_back(next_segment(i_point_index, i_advance));
            n_items++;
        end
    end

    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_pct);
        end
    end

    // output transaction check
    always @(posedge i_clk) begin
        t_seg e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_segs++;
            if (segs_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected segment x0=%0d", o_seg_x_start);
            end else begin
                e = segs_due.pop_front();
                if (e.x0 !== o_seg_x_start || e.y0 !== o_seg_y_start ||
                    e.x1 !== o_seg_x_end || e.y1 !== o_seg_y_end) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp (%0d,%0d)-(%0d,%0d) got (%0d,%0d)-(%0d,%0d)",
                                 e.x0, e.y0, e.x1, e.y1, o_seg_x_start, o_seg_y_start,
                                 o_seg_x_end, o_seg_y_end);
                end
            end
        end
    end

    task automatic send_point(int idx, bit adv);
        while ($urandom_range(99) < tx_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_point_index <= idx[7:0];
        i_advance <= adv;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (segs_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[19:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_BASE_Y:     m_base_y = value[12:0];
            CFG_AMPLITUDE:  m_amp = value[9:0];
            CFG_PERIOD:     m_period = value[11:0];
            CFG_PHASE_STEP: m_step = value[19:0];
            CFG_MOD_PERIOD: m_mod_period = value[11:0];
            CFG_MOD_ENABLE: m_mod_en = value[0];
            CFG_X_STEP:     m_x_step = value[19:0];
            default: ;
        endcase
    endtask

    task automatic test_defaults;
        send_point(0, 0);
        send_point(255, 0);
        send_point(1, 1);
        send_point(128, 1);
        send_point(85, 1);
        drain();
    endtask

    task automatic test_extremes;
        write_reg(CFG_BASE_Y, 4095);
        write_reg(CFG_AMPLITUDE, 1023);
        write_reg(CFG_PERIOD, 0);
        write_reg(CFG_PHASE_STEP, 1048575);
        write_reg(CFG_MOD_PERIOD, 0);
        write_reg(CFG_MOD_ENABLE, 1);
        write_reg(CFG_X_STEP, 1048575);
        send_point(0, 1);
        send_point(255, 1);
        drain();
        write_reg(CFG_BASE_Y, -4096);
        write_reg(CFG_PERIOD, 4095);
        write_reg(CFG_MOD_PERIOD, 4095);
        write_reg(CFG_X_STEP, 0);
        send_point(200, 1);
        send_point(255, 0);
        drain();
        write_reg(CFG_PERIOD, 1);
        write_reg(CFG_MOD_PERIOD, 1);
        write_reg(CFG_PHASE_STEP, 0);
        write_reg(CFG_AMPLITUDE, 0);
        write_reg(CFG_MOD_ENABLE, 0);
        send_point(7, 1);
        send_point(254, 0);
        drain();
    endtask

    // offset left above a lowered period stays as is
    task automatic test_single_wrap;
        write_reg(CFG_BASE_Y, 0);
        write_reg(CFG_AMPLITUDE, 700);
        write_reg(CFG_X_STEP, 1638);
        write_reg(CFG_PERIOD, 200);
        write_reg(CFG_PHASE_STEP, 199 << 8);
        send_point(3, 1);
        drain();
        write_reg(CFG_PERIOD, 50);
        send_point(3, 1);
        send_point(40, 1);
        send_point(41, 0);
        drain();
    endtask

    task automatic random_config;
        write_reg(CFG_BASE_Y, $urandom_range(8191) - 4096);
        write_reg(CFG_AMPLITUDE, $urandom_range(1023));
        write_reg(CFG_PERIOD, $urandom_range(3) == 0 ? $urandom_range(4095) : $urandom_range(300));
        write_reg(CFG_PHASE_STEP, $urandom_range(1) ? $urandom_range(1048575)
                                                    : $urandom_range(20000));
        write_reg(CFG_MOD_PERIOD, $urandom_range(4095));
        write_reg(CFG_MOD_ENABLE, $urandom_range(1));
        write_reg(CFG_X_STEP, $urandom_range(1) ? $urandom_range(1048575)
                                                : $urandom_range(4000));
    endtask

    task automatic test_random(int n, int tx, int rx);
        tx_pct = tx;
        rx_pct = rx;
        for (int i = 0; i < n; i++) begin
            if (i % 80 == 0) begin
                drain();
                random_config();
            end
            send_point($urandom_range(255), $urandom_range(1));
        end
        drain();
    endtask

    task automatic test_backpressure;
        tx_pct = 0;
        rx_pct = 0;
        random_config();
        hold_cnt = 600;
        for (int i = 0; i < 12; i++) send_point($urandom_range(255), $urandom_range(1));
        drain();
    endtask

    initial begin
        for (int k = 0; k < TABLE_N; k++) sine_tab[k] = sine_entry(k);
        m_base_y = 0;
        m_amp = 50;
        m_period = 100;
        m_step = 512;
        m_mod_period = 50;
        m_mod_en = 0;
        m_x_step = 1638;
        m_offset = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_extremes();
        test_single_wrap();
        test_backpressure();
        test_random(330, 6, 81);
        test_random(330, 81, 6);
        test_random(340, 0, 0);
        $display("covered %0d input transactions and %0d segments over random register sets,",
                 n_items, n_segs);
        $display("register extremes, offset wrap and long output backpressure");
        if (errors == 0 && segs_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d segments missing", errors, segs_due.size());
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// File: scrolling_sine_segment_generator.f
rtl/core/sssg_pkg.sv
rtl/core/sssg_sine_rom.sv
rtl/core/sssg_div.sv
rtl/core/sssg_queue.sv
rtl/core/sssg_front.sv
rtl/core/sssg_back.sv
rtl/core/scrolling_sine_segment_generator.sv
bench/tb.sv
